// ----- rtl/core/mfd_pkg.sv -----
// Shared constants for the motor feedback decoder: field and word widths,
// control register indexes and fixed-point constants. No dependencies.
`timescale 1ns / 1ps

package mfd_pkg;

   // word layout
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 224;

   // control port
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 17;

   localparam logic [CSR_ADDR_W-1:0] CSR_SPEED_ALPHA     = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_CURRENT_ALPHA   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPEED_GAIN      = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_ANGLE_PER_COUNT = 2'd3;

   // fixed-point constants
   localparam logic [16:0]        ALPHA_ONE    = 17'd65536;
   localparam logic signed [16:0] WRAP_HI      = 17'sd32768;
   localparam logic signed [16:0] WRAP_LO      = -17'sd32768;
   localparam logic [8:0]         DEG_PER_TURN = 9'd360;

   // reset values of the control registers
   localparam logic [16:0] SPEED_ALPHA_RST     = 17'd65536;
   localparam logic [16:0] CURRENT_ALPHA_RST   = 17'd65536;
   localparam logic [15:0] SPEED_GAIN_RST      = 16'd1144;
   localparam logic [15:0] ANGLE_PER_COUNT_RST = 16'd360;

endpackage

// ----- rtl/core/mfd_serial_mul.sv -----
// Radix-4 digit-serial multiplier: signed multiplicand times unsigned multiplier,
// two multiplier bits per cycle, LSB first. Standalone, no package needed.
`timescale 1ns / 1ps

module mfd_serial_mul #(
   parameter int MW = 16,
   parameter int QW = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [MW-1:0]    mcand,
   input  logic [QW-1:0]           mplier,
   output logic                    busy,
   output logic signed [MW+QW-1:0] product
);

   localparam int NSTEP = (QW + 1) / 2;
   localparam int CW    = (NSTEP > 1) ? $clog2(NSTEP) : 1;
   localparam int SW    = MW + 2;
   localparam int LW    = 2 * NSTEP;
   localparam int PW    = MW + QW;

   typedef enum logic [1:0] {U_IDLE, U_PREP, U_STEP} state_type;

   state_type             state_ff, state_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic signed [SW-1:0]  m_ff, m_in;
   logic signed [SW-1:0]  m3_ff, m3_in;
   logic [LW-1:0]         q_ff, q_in;
   logic signed [SW-1:0]  acc_ff, acc_in;
   logic [LW-1:0]         lo_ff, lo_in;
   logic signed [SW-1:0]  addend;
   logic signed [SW-1:0]  sum;
   logic [SW+LW-1:0]      full;

   // partial product for the current digit; 3M is prepared once
   always_comb begin
      unique case (q_ff[1:0])
         2'd0: addend = '0;
         2'd1: addend = m_ff;
         2'd2: addend = m_ff <<< 1;
         2'd3: addend = m3_ff;
      endcase
   end

   assign sum = acc_ff + addend;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      m_in     = m_ff;
      m3_in    = m3_ff;
      q_in     = q_ff;
      acc_in   = acc_ff;
      lo_in    = lo_ff;
      unique case (state_ff)
         U_IDLE: begin
            if (start) begin
               m_in     = SW'(mcand);
               q_in     = LW'(mplier);
               acc_in   = '0;
               lo_in    = '0;
               cnt_in   = CW'(NSTEP - 1);
               state_in = U_PREP;
            end
         end
         U_PREP: begin
            m3_in    = m_ff + (m_ff <<< 1);
            state_in = U_STEP;
         end
         U_STEP: begin
            // high part shifts right by one digit, low digit drops into lo
            acc_in = sum >>> 2;
            lo_in  = LW'({sum[1:0], lo_ff} >> 2);
            q_in   = q_ff >> 2;
            if (cnt_ff == '0) begin
               state_in = U_IDLE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         default: state_in = U_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff <= cnt_in;
      m_ff   <= m_in;
      m3_ff  <= m3_in;
      q_ff   <= q_in;
      acc_ff <= acc_in;
      lo_ff  <= lo_in;
   end

   assign full    = {acc_ff, lo_ff};
   assign busy    = (state_ff != U_IDLE);
   assign product = full[PW-1:0];

endmodule

// ----- rtl/core/motor_feedback_decode_multiturn.sv -----
// Top level of the motor feedback decoder with multi-turn angle tracking.
// Depends on mfd_pkg and mfd_serial_mul.
`timescale 1ns / 1ps

// Decodes one motor feedback word into angle, filtered speed, filtered
// current and multi-turn position. Items are handled one at a time: a word
// is taken only after the result of the previous word has been registered.
// The work is set by two chained radix-4 serial multiplies (each a start,
// one prep step and one step per 2-bit digit): speed times gain (16-bit
// multiplier), a step to form the speed difference, then the speed filter
// step (17-bit alpha), and a step to register the result; the angle,
// current-filter and turns*360 products run alongside and finish earlier.
// A finished result sits in an output register, so the next word is taken
// while it waits; the last step waits for a free output. Filters compute
// f + ((alpha*(x-f))>>>16), which equals the weighted average with floor
// rounding; alpha above 1.0 saturates to 1.0. The turn counter steps on
// encoder jumps of more than half a revolution and wraps at 32 bits. Control
// registers may be written only while no word is in flight.
module motor_feedback_decode_multiturn (
   input  logic                              clock,
   input  logic                              reset,
   // temperature_raw[7:0], current_raw[23:8], speed_raw[39:24],
   // encoder_count[55:40]
   input  logic [mfd_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // encoder_out[15:0], angle_single[47:16], speed_smoothed[79:48],
   // current_smoothed[113:80], temperature_out[121:114], turn_count[153:122],
   // multiturn_angle[217:154], zero fill above
   output logic [mfd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_wen,
   input  logic [mfd_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [mfd_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import mfd_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_LOAD, S_SPD, S_SEM, S_FIN} state_type;

   // control registers
   logic [16:0] speed_alpha_ff;
   logic [16:0] current_alpha_ff;
   logic [15:0] speed_gain_ff;
   logic [15:0] angle_per_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_alpha_ff     <= SPEED_ALPHA_RST;
         current_alpha_ff   <= CURRENT_ALPHA_RST;
         speed_gain_ff      <= SPEED_GAIN_RST;
         angle_per_count_ff <= ANGLE_PER_COUNT_RST;
      end else if (csr_wen) begin
         unique case (csr_addr)
            CSR_SPEED_ALPHA:     speed_alpha_ff     <= csr_wdata;
            CSR_CURRENT_ALPHA:   current_alpha_ff   <= csr_wdata;
            CSR_SPEED_GAIN:      speed_gain_ff      <= csr_wdata[15:0];
            CSR_ANGLE_PER_COUNT: angle_per_count_ff <= csr_wdata[15:0];
         endcase
      end
   end

   // input word fields
   logic [7:0]         req_temp;
   logic signed [15:0] req_cur;
   logic signed [15:0] req_spd;
   logic [15:0]        req_enc;

   assign req_temp = req_tdata[7:0];
   assign req_cur  = req_tdata[23:8];
   assign req_spd  = req_tdata[39:24];
   assign req_enc  = req_tdata[55:40];

   // sequencer and datapath registers
   state_type                state_ff, state_in;
   logic [7:0]               temp_ff, temp_in;
   logic [15:0]              enc_ff, enc_in;
   logic [15:0]              prev_ff, prev_in;
   logic signed [31:0]       turns_ff, turns_in;
   logic signed [34:0]       diff_c_ff, diff_c_in;
   logic signed [32:0]       diff_s_ff, diff_s_in;
   logic signed [31:0]       fs_ff, fs_in;
   logic signed [33:0]       fc_ff, fc_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;

   logic req_accept;
   logic start_ang, start_spd, start_cur, start_tot, start_sem;
   logic ang_busy, spd_busy, cur_busy, tot_busy, sem_busy;

   logic signed [16:0] ang_mcand;
   logic signed [32:0] ang_prod;
   logic signed [31:0] spd_prod;
   logic signed [51:0] cur_prod;
   logic signed [40:0] tot_prod;
   logic signed [49:0] sem_prod;

   logic [16:0]        sa_sat;
   logic [16:0]        ca_sat;
   logic signed [16:0] enc_diff;
   logic signed [31:0] fs_new;
   logic signed [33:0] fc_new;
   logic [31:0]        angle;
   logic [47:0]        total_hi;
   logic [63:0]        total;
   logic               units_idle;
   logic               out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // alpha above 1.0 saturates
   assign sa_sat = (speed_alpha_ff > ALPHA_ONE) ? ALPHA_ONE : speed_alpha_ff;
   assign ca_sat = (current_alpha_ff > ALPHA_ONE) ? ALPHA_ONE : current_alpha_ff;

   assign ang_mcand = $signed({1'b0, angle_per_count_ff});

   // encoder step, plain integer difference
   assign enc_diff = $signed({1'b0, req_enc}) - $signed({1'b0, prev_ff});

   // angle = apc * encoder
   mfd_serial_mul #(.MW(17), .QW(16)) u_ang (
      .clock   (clock),
      .reset   (reset),
      .start   (start_ang),
      .mcand   (ang_mcand),
      .mplier  (req_enc),
      .busy    (ang_busy),
      .product (ang_prod)
   );

   // speed sample = speed_raw * gain, Q16.16 rad/s
   mfd_serial_mul #(.MW(16), .QW(16)) u_spd (
      .clock   (clock),
      .reset   (reset),
      .start   (start_spd),
      .mcand   (req_spd),
      .mplier  (speed_gain_ff),
      .busy    (spd_busy),
      .product (spd_prod)
   );

   // current filter step alpha * (sample - f)
   mfd_serial_mul #(.MW(35), .QW(17)) u_cur (
      .clock   (clock),
      .reset   (reset),
      .start   (start_cur),
      .mcand   (diff_c_ff),
      .mplier  (ca_sat),
      .busy    (cur_busy),
      .product (cur_prod)
   );

   // turns * 360
   mfd_serial_mul #(.MW(32), .QW(9)) u_tot (
      .clock   (clock),
      .reset   (reset),
      .start   (start_tot),
      .mcand   (turns_ff),
      .mplier  (DEG_PER_TURN),
      .busy    (tot_busy),
      .product (tot_prod)
   );

   // speed filter step alpha * (sample - f)
   mfd_serial_mul #(.MW(33), .QW(17)) u_sem (
      .clock   (clock),
      .reset   (reset),
      .start   (start_sem),
      .mcand   (diff_s_ff),
      .mplier  (sa_sat),
      .busy    (sem_busy),
      .product (sem_prod)
   );

   // filter update: f + floor(alpha*(x-f) / 2^16), modulo the state width
   assign fs_new = fs_ff + sem_prod[47:16];
   assign fc_new = fc_ff + cur_prod[49:16];
   assign angle  = ang_prod[31:0];

   // total = (turns*360 << 16) + angle; low half-word is angle's own
   assign total_hi = {{7{tot_prod[40]}}, tot_prod} + {32'b0, angle[31:16]};
   assign total    = {total_hi, angle[15:0]};

   assign units_idle = !(ang_busy || cur_busy || tot_busy || sem_busy);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      temp_in      = temp_ff;
      enc_in       = enc_ff;
      prev_in      = prev_ff;
      turns_in     = turns_ff;
      diff_c_in    = diff_c_ff;
      diff_s_in    = diff_s_ff;
      fs_in        = fs_ff;
      fc_in        = fc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      start_ang    = 1'b0;
      start_spd    = 1'b0;
      start_cur    = 1'b0;
      start_tot    = 1'b0;
      start_sem    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               temp_in   = req_temp;
               enc_in    = req_enc;
               prev_in   = req_enc;
               start_ang = 1'b1;
               start_spd = 1'b1;
               diff_c_in = 35'($signed({req_cur, 16'b0})) - 35'(fc_ff);
               // jump of more than half a turn: wrapped backward or forward
               if (enc_diff > WRAP_HI) begin
                  turns_in = turns_ff - 32'sd1;
               end else if (enc_diff < WRAP_LO) begin
                  turns_in = turns_ff + 32'sd1;
               end
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            start_cur = 1'b1;
            start_tot = 1'b1;
            state_in  = S_SPD;
         end
         S_SPD: begin
            if (!spd_busy) begin
               diff_s_in = 33'(spd_prod) - 33'(fs_ff);
               state_in  = S_SEM;
            end
         end
         S_SEM: begin
            start_sem = 1'b1;
            state_in  = S_FIN;
         end
         S_FIN: begin
            if (units_idle && out_free) begin
               fs_in        = fs_new;
               fc_in        = fc_new;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'b0, total, turns_ff, temp_ff, fc_new, fs_new,
                               angle, enc_ff};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         prev_ff      <= '0;
         turns_ff     <= '0;
         fs_ff        <= '0;
         fc_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_ff      <= prev_in;
         turns_ff     <= turns_in;
         fs_ff        <= fs_in;
         fc_ff        <= fc_in;
      end
      temp_ff     <= temp_in;
      enc_ff      <= enc_in;
      diff_c_ff   <= diff_c_in;
      diff_s_ff   <= diff_s_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
